>>> hw/rtl/rodrigues_to_quaternion_assert.svh
`ifndef RODRIGUES_TO_QUATERNION_ASSERT_SVH
`define RODRIGUES_TO_QUATERNION_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define RTQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define RTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/rtq_pkg.sv
package rtq_pkg;

    localparam int AXES     = 3;
    localparam int LANES    = AXES + 1;
    localparam int ROD_W    = 32;
    localparam int MAG_W    = 32;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int QUO_W    = 63;
    localparam int REM_W    = SQ_W + 1;
    localparam int RAD_W    = 64;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int SQR_W    = ROOT_W + 2;
    localparam int SCALAR_W = 31;
    localparam int QUAT_W   = 32;

    // lane order through the divider and root pipelines
    localparam int LANE_SCALAR = 0;
    localparam int LANE_I      = 1;
    localparam int LANE_J      = 2;
    localparam int LANE_K      = 3;

    // 1.0 in Q32.32, the constant term of 1 + |r|^2
    localparam logic [SQ_W-1:0]     NORM_ONE = 64'h0000_0001_0000_0000;
    localparam logic [SCALAR_W-1:0] Q30_ONE  = 31'h4000_0000;

    typedef struct packed {
        logic signed [ROD_W-1:0] rod_x;
        logic signed [ROD_W-1:0] rod_y;
        logic signed [ROD_W-1:0] rod_z;
    } t_rod_req;

    typedef struct packed {
        logic        [SCALAR_W-1:0] quat_scalar;
        logic signed [QUAT_W-1:0]   quat_i;
        logic signed [QUAT_W-1:0]   quat_j;
        logic signed [QUAT_W-1:0]   quat_k;
    } t_quat_resp;

    typedef struct packed {
        logic            valid;
        logic [AXES-1:0] neg;
    } t_ctl;

endpackage

>>> hw/rtl/rodrigues_to_quaternion.sv
// channel   direction  handshake                     payload
// request   in         i_in_valid / o_in_ready       i_in_data   (rod_x, rod_y, rod_z)
// result    out        o_out_valid / i_out_ready     o_out_data  (quat_scalar, quat_i/j/k)
//
// one request per cycle while o_in_ready is high; each result passes through
// 3 norm stages, 63 divider stages at one quotient bit each, 32 root stages and 1 output
// synchronous active-low reset clears the valid bits of every stage and the output
// the pipeline freezes only while its last stage holds a result and the output
// register is full and not taken; a bubble in the last stage never holds it back
`include "rodrigues_to_quaternion_assert.svh"

module rodrigues_to_quaternion (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rtq_pkg::t_rod_req   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rtq_pkg::t_quat_resp o_out_data
);
    import rtq_pkg::*;

    logic              w_en;
    logic              w_load;
    t_ctl              w_norm_ctl;
    t_ctl              w_div_ctl;
    t_ctl              w_sqrt_ctl;
    logic [SQ_W-1:0]   w_norm;
    logic [SQ_W-1:0]   w_num  [LANES];
    logic [QUO_W-1:0]  w_quo  [LANES];
    logic [ROOT_W-1:0] w_root [LANES];
    logic [ROOT_W:0]   w_inc  [LANES];
    logic [ROOT_W-1:0] w_q    [LANES];
    t_quat_resp        n_out_data;
    t_quat_resp        r_out_data;
    logic              r_out_valid;

    assign w_en       = !(w_sqrt_ctl.valid && r_out_valid && !i_out_ready);
    assign o_in_ready = w_en;
    assign w_load     = w_sqrt_ctl.valid && (!r_out_valid || i_out_ready);

    rtq_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_req   (i_in_data),
        .o_ctl   (w_norm_ctl),
        .o_norm  (w_norm),
        .o_num   (w_num)
    );

    rtq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_norm_ctl),
        .i_norm  (w_norm),
        .i_num   (w_num),
        .o_ctl   (w_div_ctl),
        .o_quo   (w_quo)
    );

    rtq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_div_ctl),
        .i_rad   (w_quo),
        .o_ctl   (w_sqrt_ctl),
        .o_root  (w_root)
    );

    // largest q with 2q-1 <= root, i.e. round half up
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_inc[l] = {1'b0, w_root[l]} + (ROOT_W + 1)'(1);
            w_q[l]   = w_inc[l][ROOT_W:1];
        end
        n_out_data.quat_scalar = w_q[LANE_SCALAR][SCALAR_W-1:0];
        n_out_data.quat_i = w_sqrt_ctl.neg[0] ? QUAT_W'(~w_q[LANE_I] + ROOT_W'(1))
                                              : QUAT_W'(w_q[LANE_I]);
        n_out_data.quat_j = w_sqrt_ctl.neg[1] ? QUAT_W'(~w_q[LANE_J] + ROOT_W'(1))
                                              : QUAT_W'(w_q[LANE_J]);
        n_out_data.quat_k = w_sqrt_ctl.neg[2] ? QUAT_W'(~w_q[LANE_K] + ROOT_W'(1))
                                              : QUAT_W'(w_q[LANE_K]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `RTQ_ASSERT_NOW(a_scalar_range, i_clk, i_rst_n, r_out_valid,
        (r_out_data.quat_scalar != '0) && (r_out_data.quat_scalar <= Q30_ONE),
        "scalar part out of range")
    `RTQ_ASSERT_NEXT(a_tail_held, i_clk, i_rst_n,
        w_sqrt_ctl.valid && r_out_valid && !i_out_ready,
        w_sqrt_ctl.valid && $stable(w_root[LANE_SCALAR]) && $stable(w_root[LANE_I]),
        "pipeline tail moved during stall")

endmodule

>>> hw/rtl/rtq_norm.sv
module rtq_norm (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  rtq_pkg::t_rod_req        i_req,
    output rtq_pkg::t_ctl            o_ctl,
    output logic [rtq_pkg::SQ_W-1:0] o_norm,
    output logic [rtq_pkg::SQ_W-1:0] o_num [rtq_pkg::LANES]
);
    import rtq_pkg::*;

    logic [ROD_W-1:0] w_rod [AXES];
    logic [AXES-1:0]  w_neg;
    logic [MAG_W-1:0] n_mag [AXES];
    t_ctl             r_ctl_a;
    t_ctl             r_ctl_b;
    t_ctl             r_ctl_c;
    logic [MAG_W-1:0] r_mag [AXES];
    logic [SQ_W-1:0]  r_sq [AXES];
    logic [SQ_W-1:0]  r_norm;
    logic [SQ_W-1:0]  r_num [LANES];

    assign w_rod[0] = i_req.rod_x;
    assign w_rod[1] = i_req.rod_y;
    assign w_rod[2] = i_req.rod_z;

    // most negative code gives 2^31, which still fits unsigned
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            w_neg[a] = w_rod[a][ROD_W-1];
            n_mag[a] = w_neg[a] ? (~w_rod[a]) + MAG_W'(1) : w_rod[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_a <= '0;
            r_ctl_b <= '0;
            r_ctl_c <= '0;
        end else if (i_en) begin
            r_ctl_a.valid <= i_valid;
            r_ctl_a.neg   <= w_neg;
            r_ctl_b       <= r_ctl_a;
            r_ctl_c       <= r_ctl_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < AXES; a++) begin
                r_mag[a] <= n_mag[a];
                r_sq[a]  <= r_mag[a] * r_mag[a];
            end
            r_norm              <= NORM_ONE + r_sq[0] + r_sq[1] + r_sq[2];
            r_num[LANE_SCALAR]  <= NORM_ONE;
            r_num[LANE_I]       <= r_sq[0];
            r_num[LANE_J]       <= r_sq[1];
            r_num[LANE_K]       <= r_sq[2];
        end
    end

    assign o_ctl  = r_ctl_c;
    assign o_norm = r_norm;
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_num[l] = r_num[l];
        end
    end

endmodule

>>> hw/rtl/rtq_div.sv
`include "rodrigues_to_quaternion_assert.svh"

module rtq_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  rtq_pkg::t_ctl             i_ctl,
    input  logic [rtq_pkg::SQ_W-1:0]  i_norm,
    input  logic [rtq_pkg::SQ_W-1:0]  i_num [rtq_pkg::LANES],
    output rtq_pkg::t_ctl             o_ctl,
    output logic [rtq_pkg::QUO_W-1:0] o_quo [rtq_pkg::LANES]
);
    import rtq_pkg::*;

    t_ctl             r_ctl  [QUO_W];
    logic [SQ_W-1:0]  r_norm [QUO_W];
    logic [REM_W-1:0] r_rem  [QUO_W][LANES];
    logic [QUO_W-1:0] r_quo  [QUO_W][LANES];

    logic [SQ_W-1:0]  w_norm_in [QUO_W];
    logic [REM_W-1:0] w_part    [QUO_W][LANES];
    logic [QUO_W-1:0] w_quo_in  [QUO_W][LANES];
    logic             w_ge      [QUO_W][LANES];
    logic [REM_W-1:0] n_rem     [QUO_W][LANES];
    logic [QUO_W-1:0] n_quo     [QUO_W][LANES];
    logic [LANES-1:0] w_rem_lt;

    // fraction long division: num * 2^62 / norm, one quotient bit per stage;
    // first stage takes num unshifted (only 1.0 / 1.0 sets that bit)
    always_comb begin
        w_norm_in[0] = i_norm;
        for (int l = 0; l < LANES; l++) begin
            w_part[0][l]   = {1'b0, i_num[l]};
            w_quo_in[0][l] = '0;
        end
        for (int s = 1; s < QUO_W; s++) begin
            w_norm_in[s] = r_norm[s-1];
            for (int l = 0; l < LANES; l++) begin
                w_part[s][l]   = {r_rem[s-1][l][REM_W-2:0], 1'b0};
                w_quo_in[s][l] = r_quo[s-1][l];
            end
        end
    end

    always_comb begin
        for (int s = 0; s < QUO_W; s++) begin
            for (int l = 0; l < LANES; l++) begin
                w_ge[s][l]  = w_part[s][l] >= {1'b0, w_norm_in[s]};
                n_rem[s][l] = w_ge[s][l] ? w_part[s][l] - {1'b0, w_norm_in[s]}
                                         : w_part[s][l];
                n_quo[s][l] = {w_quo_in[s][l][QUO_W-2:0], w_ge[s][l]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < QUO_W; s++) begin
                r_ctl[s] <= '0;
            end
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
            for (int s = 1; s < QUO_W; s++) begin
                r_ctl[s] <= r_ctl[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < QUO_W; s++) begin
                r_norm[s] <= w_norm_in[s];
                for (int l = 0; l < LANES; l++) begin
                    r_rem[s][l] <= n_rem[s][l];
                    r_quo[s][l] <= n_quo[s][l];
                end
            end
        end
    end

    assign o_ctl = r_ctl[QUO_W-1];
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quo[l] = r_quo[QUO_W-1][l];
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_rem_lt[l] = r_rem[QUO_W-1][l] < {1'b0, r_norm[QUO_W-1]};
        end
    end

    `RTQ_ASSERT_NOW(a_vec_no_top_bit, i_clk, i_rst_n, r_ctl[0].valid,
        !(r_quo[0][LANE_I][0] || r_quo[0][LANE_J][0] || r_quo[0][LANE_K][0]),
        "vector lane quotient reached one")
    `RTQ_ASSERT_NOW(a_rem_below_norm, i_clk, i_rst_n, r_ctl[QUO_W-1].valid,
        &w_rem_lt, "divider remainder not below divisor")

endmodule

>>> hw/rtl/rtq_sqrt.sv
`include "rodrigues_to_quaternion_assert.svh"

module rtq_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  rtq_pkg::t_ctl              i_ctl,
    input  logic [rtq_pkg::QUO_W-1:0]  i_rad [rtq_pkg::LANES],
    output rtq_pkg::t_ctl              o_ctl,
    output logic [rtq_pkg::ROOT_W-1:0] o_root [rtq_pkg::LANES]
);
    import rtq_pkg::*;

    localparam logic [ROOT_W-1:0] ROOT_MAX = ROOT_W'(1) << (ROOT_W - 1);

    t_ctl              r_ctl  [ROOT_W];
    logic [RAD_W-1:0]  r_rad  [ROOT_W-1][LANES];
    logic [SQR_W-1:0]  r_rem  [ROOT_W][LANES];
    logic [ROOT_W-1:0] r_root [ROOT_W][LANES];

    logic [RAD_W-1:0]   w_rad_in  [ROOT_W][LANES];
    logic [SQR_W-1:0]   w_rem_in  [ROOT_W][LANES];
    logic [ROOT_W-1:0]  w_root_in [ROOT_W][LANES];
    logic [SQR_W+1:0]   w_part    [ROOT_W][LANES];
    logic [SQR_W+1:0]   w_trial   [ROOT_W][LANES];
    logic               w_ge      [ROOT_W][LANES];
    logic [SQR_W-1:0]   n_rem     [ROOT_W][LANES];
    logic [ROOT_W-1:0]  n_root    [ROOT_W][LANES];
    logic [LANES-1:0]   w_rem_ok;
    logic [LANES-1:0]   w_root_ok;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_rad_in[0][l]  = RAD_W'(i_rad[l]);
            w_rem_in[0][l]  = '0;
            w_root_in[0][l] = '0;
        end
        for (int s = 1; s < ROOT_W; s++) begin
            for (int l = 0; l < LANES; l++) begin
                w_rad_in[s][l]  = r_rad[s-1][l];
                w_rem_in[s][l]  = r_rem[s-1][l];
                w_root_in[s][l] = r_root[s-1][l];
            end
        end
    end

    // one root bit per stage from the top two radicand bits
    always_comb begin
        for (int s = 0; s < ROOT_W; s++) begin
            for (int l = 0; l < LANES; l++) begin
                w_part[s][l]  = {w_rem_in[s][l], w_rad_in[s][l][RAD_W-1 -: 2]};
                w_trial[s][l] = {2'b00, w_root_in[s][l], 2'b01};
                w_ge[s][l]    = w_part[s][l] >= w_trial[s][l];
                n_rem[s][l]   = w_ge[s][l] ? SQR_W'(w_part[s][l] - w_trial[s][l])
                                           : SQR_W'(w_part[s][l]);
                n_root[s][l]  = {w_root_in[s][l][ROOT_W-2:0], w_ge[s][l]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < ROOT_W; s++) begin
                r_ctl[s] <= '0;
            end
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
            for (int s = 1; s < ROOT_W; s++) begin
                r_ctl[s] <= r_ctl[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < ROOT_W; s++) begin
                for (int l = 0; l < LANES; l++) begin
                    r_rem[s][l]  <= n_rem[s][l];
                    r_root[s][l] <= n_root[s][l];
                end
            end
            for (int s = 0; s < ROOT_W - 1; s++) begin
                for (int l = 0; l < LANES; l++) begin
                    r_rad[s][l] <= {w_rad_in[s][l][RAD_W-3:0], 2'b00};
                end
            end
        end
    end

    assign o_ctl = r_ctl[ROOT_W-1];
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_root[l] = r_root[ROOT_W-1][l];
        end
    end

    // integer root leaves at most 2r behind
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_rem_ok[l]  = r_rem[ROOT_W-1][l] <= {1'b0, r_root[ROOT_W-1][l], 1'b0};
            w_root_ok[l] = r_root[ROOT_W-1][l] <= ROOT_MAX;
        end
    end

    `RTQ_ASSERT_NOW(a_root_rem, i_clk, i_rst_n, r_ctl[ROOT_W-1].valid,
        &w_rem_ok, "root remainder above twice the root")
    `RTQ_ASSERT_NOW(a_root_range, i_clk, i_rst_n, r_ctl[ROOT_W-1].valid,
        &w_root_ok, "root above 2^31")

endmodule
